/* hw/rtl/command_replay_filter_top_assert.svh */
// ---------------------------------------------------------------------------
// command_replay_filter_top_assert
// assertion macros for the replay filter, clocked on clock, held off in reset
// ---------------------------------------------------------------------------
`ifndef COMMAND_REPLAY_FILTER_TOP_ASSERT_SVH
`define COMMAND_REPLAY_FILTER_TOP_ASSERT_SVH

// consequent must hold in the same cycle
`define CRF_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold in the next cycle
`define CRF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/crf_pkg.sv */
// ---------------------------------------------------------------------------
// crf_pkg
// shared widths, types and constants of the command replay filter
// ---------------------------------------------------------------------------
package crf_pkg;

   localparam int unsigned SRC_W  = 16;
   localparam int unsigned NUM_W  = 8;
   localparam int unsigned TIME_W = 32;
   localparam int unsigned SLOT_W = 4;

   localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd5000;

   typedef struct packed {
      logic [SRC_W-1:0]  source;
      logic [NUM_W-1:0]  number;
      logic [TIME_W-1:0] arrive_ms;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_DONE = 3'b100
   } state_type;

endpackage

/* hw/rtl/crf_req_if.sv */
// ---------------------------------------------------------------------------
// crf_req_if
// command channel: source address, command number and current time
// ---------------------------------------------------------------------------
interface crf_req_if;
   logic                         valid;
   logic                         ready;
   logic [crf_pkg::SRC_W-1:0]    source_address;
   logic [crf_pkg::NUM_W-1:0]    command_number;
   logic [crf_pkg::TIME_W-1:0]   now_ms;

   modport source (output valid, output source_address, output command_number,
                   output now_ms, input ready);
   modport sink   (input valid, input source_address, input command_number,
                   input now_ms, output ready);
endinterface

/* hw/rtl/crf_rsp_if.sv */
// ---------------------------------------------------------------------------
// crf_rsp_if
// verdict channel: fresh flag and the slot that was written
// ---------------------------------------------------------------------------
interface crf_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         fresh;
   logic [crf_pkg::SLOT_W-1:0]   slot_written;

   modport source (output valid, output fresh, output slot_written, input ready);
   modport sink   (input valid, input fresh, input slot_written, output ready);
endinterface

/* hw/rtl/crf_ram.sv */
// ---------------------------------------------------------------------------
// crf_ram
// generic single write, single read ram with registered read data
// ---------------------------------------------------------------------------
module crf_ram #(
   parameter int unsigned WIDTH = 56,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/command_replay_filter_top.sv */
// ---------------------------------------------------------------------------
// command_replay_filter_top
// replay filter: one table entry is read and checked per cycle by a shared
// add/compare unit; a fresh command overwrites the oldest entry
// ---------------------------------------------------------------------------
// flow: an accepted beat starts a scan that checks the entries in order, then
//   the verdict is registered; a duplicate ends the scan early at its entry
// occupancy: one command at a time, no new beat is taken until the verdict
//   is issued, since the single table read port feeds one compare unit
// reset: synchronous; table reads as all zero via per-entry valid bits,
//   timeout returns to 5000, no clearing pass
`include "command_replay_filter_top_assert.svh"

module command_replay_filter_top #(
   parameter int unsigned TABLE_ENTRIES = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [crf_pkg::TIME_W-1:0]        csr_wr_data,
   crf_req_if.sink                           req,
   crf_rsp_if.source                         rsp
);

   localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
   localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);
   localparam int unsigned ENT_W = $bits(crf_pkg::entry_type);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TABLE_ENTRIES);

   crf_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [IDX_W-1:0]   rd_idx_ff;
   logic               ent_vld_ff;
   logic [TABLE_ENTRIES-1:0] valid_ff, valid_in;

   logic [crf_pkg::SRC_W-1:0]  src_ff, src_in;
   logic [crf_pkg::NUM_W-1:0]  num_ff, num_in;
   logic [crf_pkg::TIME_W-1:0] now_ff, now_in;
   logic [crf_pkg::TIME_W-1:0] min_time_ff, min_time_in;
   logic [IDX_W-1:0]           slot_ff, slot_in;
   logic                       fresh_ff, fresh_in;
   logic [crf_pkg::TIME_W-1:0] timeout_ff;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_fresh_ff, rsp_fresh_in;
   logic [crf_pkg::SLOT_W-1:0]  rsp_slot_ff, rsp_slot_in;

   logic [IDX_W-1:0]        rd_addr;
   logic [ENT_W-1:0]        rd_data;
   crf_pkg::entry_type      ent;
   crf_pkg::entry_type      wr_ent;
   logic                    wr_en;
   logic [crf_pkg::TIME_W:0] expiry;
   logic                    hit;
   logic                    lower;
   logic                    req_beat;
   logic [IDX_W+crf_pkg::SLOT_W-1:0] slot_wide;

   // table storage
   crf_ram #(
      .WIDTH (ENT_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (slot_ff),
      .wr_data (wr_ent),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_beat = req.valid && req.ready;
   assign rd_addr  = (cnt_ff < CNT_LAST) ? cnt_ff[IDX_W-1:0] : '0;
   assign wr_ent   = '{source: src_ff, number: num_ff, arrive_ms: now_ff};

   // shared compare unit: one entry per cycle, never-written entries read as zero
   always_comb begin
      ent    = ent_vld_ff ? crf_pkg::entry_type'(rd_data) : '0;
      expiry = {1'b0, ent.arrive_ms} + {1'b0, timeout_ff};
      hit    = (ent.source == src_ff) && (ent.number == num_ff) &&
               (expiry > {1'b0, now_ff});
      lower  = (cnt_ff == CNT_W'(1)) || (ent.arrive_ms < min_time_ff);
   end

   assign slot_wide = {{crf_pkg::SLOT_W{1'b0}}, slot_ff};

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      valid_in     = valid_ff;
      src_in       = src_ff;
      num_in       = num_ff;
      now_in       = now_ff;
      min_time_in  = min_time_ff;
      slot_in      = slot_ff;
      fresh_in     = fresh_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_fresh_in = rsp_fresh_ff;
      rsp_slot_in  = rsp_slot_ff;
      wr_en        = 1'b0;

      case (state_ff)
         crf_pkg::ST_IDLE: begin
            if (req_beat) begin
               src_in   = req.source_address;
               num_in   = req.command_number;
               now_in   = req.now_ms;
               cnt_in   = '0;
               state_in = crf_pkg::ST_SCAN;
            end
         end
         crf_pkg::ST_SCAN: begin
            cnt_in = cnt_ff + CNT_W'(1);
            // read data is registered and lags the address, so no entry is checked while cnt is zero
            if (cnt_ff != '0) begin
               if (hit) begin
                  fresh_in = 1'b0;
                  state_in = crf_pkg::ST_DONE;
               end else begin
                  if (lower) begin
                     min_time_in = ent.arrive_ms;
                     slot_in     = rd_idx_ff;
                  end
                  if (cnt_ff == CNT_LAST) begin
                     fresh_in = 1'b1;
                     state_in = crf_pkg::ST_DONE;
                  end
               end
            end
         end
         crf_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               rsp_fresh_in = fresh_ff;
               rsp_slot_in  = fresh_ff ? slot_wide[crf_pkg::SLOT_W-1:0] : '0;
               wr_en        = fresh_ff;
               if (fresh_ff) begin
                  valid_in[slot_ff] = 1'b1;
               end
               state_in = crf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = crf_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= crf_pkg::ST_IDLE;
         cnt_ff       <= '0;
         valid_ff     <= '0;
         timeout_ff   <= crf_pkg::TIMEOUT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            timeout_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      src_ff       <= src_in;
      num_ff       <= num_in;
      now_ff       <= now_in;
      min_time_ff  <= min_time_in;
      slot_ff      <= slot_in;
      fresh_ff     <= fresh_in;
      rsp_fresh_ff <= rsp_fresh_in;
      rsp_slot_ff  <= rsp_slot_in;
      rd_idx_ff    <= rd_addr;
      ent_vld_ff   <= valid_ff[rd_addr];
   end

   assign req.ready        = (state_ff == crf_pkg::ST_IDLE);
   assign rsp.valid        = rsp_valid_ff;
   assign rsp.fresh        = rsp_fresh_ff;
   assign rsp.slot_written = rsp_slot_ff;

   `CRF_ASSERT_NEXT(a_beat_starts_scan, req_beat, (state_ff == crf_pkg::ST_SCAN) && (cnt_ff == '0), "accepted beat did not start a scan")
   `CRF_ASSERT_NOW(a_scan_bound, state_ff == crf_pkg::ST_SCAN, cnt_ff <= CNT_LAST, "scan counter ran past the table")
   `CRF_ASSERT_NOW(a_rsp_from_done, $rose(rsp_valid_ff), $past(state_ff) == crf_pkg::ST_DONE, "verdict raised outside done state")
   `CRF_ASSERT_NOW(a_dup_slot_zero, rsp.valid && !rsp.fresh, rsp.slot_written == '0, "duplicate verdict carries a slot")

endmodule

/* bench/tb_command_replay_filter_top.sv */
// ---------------------------------------------------------------------------
// tb_command_replay_filter_top
// self-checking bench for the replay filter: a queue-fed command driver with
// bursty pacing, a verdict monitor with its own stall pattern and a table
// predictor, run across several timeout settings including both extremes
// ---------------------------------------------------------------------------
module tb_command_replay_filter_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned TABLE_ENTRIES    = 16;
   localparam int unsigned LIMIT_CYCLES     = 1_000_000;
   localparam int unsigned HOLD_OFF_CYCLES  = 400;
   localparam int unsigned RANDOM_PER_PHASE = 203;
   localparam int unsigned HISTORY_DEPTH    = 24;

   localparam logic [crf_pkg::TIME_W-1:0] TIMEOUT_PLAN [6] =
      '{32'd1, 32'd100, 32'd5000, 32'd60000, 32'h8000_0000, 32'd0};
   localparam logic [crf_pkg::SRC_W-1:0] SRC_POOL [8] =
      '{16'h0000, 16'hFFFF, 16'h0001, 16'h0002, 16'h8000, 16'h7FFF, 16'h1234, 16'hC001};
   localparam logic [crf_pkg::NUM_W-1:0] NUM_POOL [4] = '{8'h00, 8'h01, 8'h80, 8'hFF};

   typedef struct packed {
      logic [crf_pkg::SRC_W-1:0]  source;
      logic [crf_pkg::NUM_W-1:0]  number;
      logic [crf_pkg::TIME_W-1:0] now_ms;
   } command_type;

   typedef struct packed {
      logic                       fresh;
      logic [crf_pkg::SLOT_W-1:0] slot;
   } verdict_type;

   typedef enum logic [1:0] {RX_ALWAYS, RX_COIN, RX_SPARSE} rx_mode_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic [crf_pkg::TIME_W-1:0] csr_wr_data;

   crf_req_if cmd_ch ();
   crf_rsp_if verdict_ch ();

   command_replay_filter_top #(.TABLE_ENTRIES(TABLE_ENTRIES)) dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req         (cmd_ch),
      .rsp         (verdict_ch)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor copy of the table and the timeout
   logic [crf_pkg::SRC_W-1:0]  seen_source [TABLE_ENTRIES] = '{default: '0};
   logic [crf_pkg::NUM_W-1:0]  seen_number [TABLE_ENTRIES] = '{default: '0};
   logic [crf_pkg::TIME_W-1:0] seen_time   [TABLE_ENTRIES] = '{default: '0};
   logic [crf_pkg::TIME_W-1:0] timeout_setting;

   command_type commands_pending [$];
   command_type recent_commands [$];
   verdict_type verdicts_due [$];
   logic [crf_pkg::TIME_W-1:0] clock_ms;

   int unsigned commands_added    = 0;
   int unsigned beats_in          = 0;
   int unsigned verdicts_fresh    = 0;
   int unsigned verdicts_blocked  = 0;
   int unsigned settings_used     = 1;
   int unsigned mismatches        = 0;
   int unsigned hold_off_asked    = 0;
   int unsigned hold_off_served   = 0;
   int unsigned cycles_run        = 0;

   function automatic verdict_type judge_command(command_type cmd);
      verdict_type v;
      logic        replay_hit;
      int unsigned oldest;
      replay_hit = 1'b0;
      oldest = 0;
      for (int unsigned i = 0; i < TABLE_ENTRIES; i++) begin
         // expiry is formed at 33 bits so it never wraps
         if (seen_source[i] == cmd.source && seen_number[i] == cmd.number &&
             ({1'b0, seen_time[i]} + {1'b0, timeout_setting}) > {1'b0, cmd.now_ms})
            replay_hit = 1'b1;
         if (seen_time[i] < seen_time[oldest])
            oldest = i;
      end
      if (replay_hit) begin
         v.fresh = 1'b0;
         v.slot = '0;
      end else begin
         seen_source[oldest] = cmd.source;
         seen_number[oldest] = cmd.number;
         seen_time[oldest] = cmd.now_ms;
         v.fresh = 1'b1;
         v.slot = oldest[crf_pkg::SLOT_W-1:0];
      end
      return v;
   endfunction

   task automatic add_command(logic [crf_pkg::SRC_W-1:0] source,
                              logic [crf_pkg::NUM_W-1:0] number,
                              logic [crf_pkg::TIME_W-1:0] now_ms);
      command_type c;
      c.source = source;
      c.number = number;
      c.now_ms = now_ms;
      commands_pending.push_back(c);
      recent_commands.push_back(c);
      if (recent_commands.size() > HISTORY_DEPTH)
         void'(recent_commands.pop_front());
      commands_added++;
   endtask

   // mostly repeats of recent commands and a small pool of senders, some noise
   task automatic add_random(int unsigned count);
      command_type                old;
      logic [crf_pkg::TIME_W-1:0] step_max;
      logic [crf_pkg::TIME_W-1:0] window;
      int unsigned                pick;
      step_max = (timeout_setting > 32'd64) ? (timeout_setting >> 3) : 32'd4;
      clock_ms = $urandom;
      for (int unsigned k = 0; k < count; k++) begin
         pick = $urandom_range(0, 9);
         if (pick < 2) begin
            add_command(16'($urandom), 8'($urandom), $urandom);
         end else if (pick < 6 && recent_commands.size() > 0) begin
            old = recent_commands[$urandom_range(0, recent_commands.size() - 1)];
            window = (timeout_setting == 0) ? 32'd0 : $urandom % timeout_setting;
            case ($urandom_range(0, 3))
               0: add_command(old.source, old.number, old.now_ms + window);
               // right at the edge of the blocking window
               1: add_command(old.source, old.number,
                              old.now_ms + timeout_setting + $urandom_range(0, 2) - 1);
               2: add_command(old.source, old.number,
                              old.now_ms + timeout_setting + ($urandom % (step_max + 1)));
               default: add_command(old.source, old.number,
                                    old.now_ms - $urandom_range(0, 50));
            endcase
         end else begin
            clock_ms = clock_ms + ($urandom % (step_max + 1));
            add_command(SRC_POOL[$urandom_range(0, 7)], NUM_POOL[$urandom_range(0, 3)],
                        clock_ms);
         end
      end
   endtask

   task automatic wait_for_drain();
      do @(posedge clock);
      while (beats_in != commands_added || verdicts_due.size() != 0);
      repeat (TABLE_ENTRIES + 3) @(posedge clock);
   endtask

   task automatic write_timeout(logic [crf_pkg::TIME_W-1:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      timeout_setting = value;
      settings_used++;
   endtask

   // command driver: bursts of beats with random gaps between them
   int unsigned burst_left = 1;
   int unsigned gap_left = 0;

   always @(posedge clock) begin : command_driver
      command_type next_cmd;
      logic        next_valid;
      if (reset) begin
         cmd_ch.valid <= 1'b0;
      end else begin
         if (cmd_ch.valid && cmd_ch.ready) begin
            verdicts_due.push_back(judge_command({cmd_ch.source_address,
                                                  cmd_ch.command_number, cmd_ch.now_ms}));
            beats_in++;
         end
         if (!cmd_ch.valid || cmd_ch.ready) begin
            next_valid = 1'b0;
            if (gap_left > 0) begin
               gap_left--;
            end else if (commands_pending.size() > 0) begin
               next_cmd = commands_pending.pop_front();
               cmd_ch.source_address <= next_cmd.source;
               cmd_ch.command_number <= next_cmd.number;
               cmd_ch.now_ms <= next_cmd.now_ms;
               next_valid = 1'b1;
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 12);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
               end
            end
            cmd_ch.valid <= next_valid;
         end
      end
   end

   // verdict monitor and receiver stall pattern
   rx_mode_type rx_mode = RX_ALWAYS;
   int unsigned rx_left = 0;
   int unsigned rx_tick = 0;
   int unsigned hold_left = 0;

   always @(posedge clock) begin : verdict_monitor
      verdict_type want;
      if (reset) begin
         verdict_ch.ready <= 1'b0;
      end else begin
         if (verdict_ch.valid && verdict_ch.ready) begin
            if (verdicts_due.size() == 0) begin
               $display("%0t: verdict beat with nothing expected, fresh %0b slot %0d",
                        $time, verdict_ch.fresh, verdict_ch.slot_written);
               mismatches++;
            end else begin
               want = verdicts_due.pop_front();
               if (verdict_ch.fresh !== want.fresh) begin
                  $display("%0t: fresh expected %0b got %0b", $time, want.fresh,
                           verdict_ch.fresh);
                  mismatches++;
               end
               if (verdict_ch.slot_written !== want.slot) begin
                  $display("%0t: slot_written expected %0d got %0d", $time, want.slot,
                           verdict_ch.slot_written);
                  mismatches++;
               end
               if (want.fresh)
                  verdicts_fresh++;
               else
                  verdicts_blocked++;
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            verdict_ch.ready <= 1'b0;
         end else if (hold_off_served != hold_off_asked) begin
            // long hold-off so the block backs up into the command channel
            hold_off_served++;
            hold_left = HOLD_OFF_CYCLES;
            verdict_ch.ready <= 1'b0;
         end else begin
            if (rx_left == 0) begin
               rx_mode = rx_mode_type'($urandom_range(0, 2));
               rx_left = $urandom_range(20, 300);
            end
            rx_left--;
            rx_tick++;
            case (rx_mode)
               RX_ALWAYS: verdict_ch.ready <= 1'b1;
               RX_COIN:   verdict_ch.ready <= 1'($urandom_range(0, 1));
               default:   verdict_ch.ready <= (rx_tick % 4 == 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      cycles_run++;
      if (cycles_run == LIMIT_CYCLES) begin
         $display("%0t: run stopped at cycle limit, %0d of %0d commands accepted",
                  $time, beats_in, commands_added);
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin : stimulus
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      cmd_ch.valid = 1'b0;
      cmd_ch.source_address = '0;
      cmd_ch.command_number = '0;
      cmd_ch.now_ms = '0;
      verdict_ch.ready = 1'b0;
      timeout_setting = crf_pkg::TIMEOUT_RESET;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset timeout: cleared entries block source 0 number 0 until it expires
      add_command(16'h0000, 8'h00, 32'd0);
      add_command(16'h0000, 8'h00, 32'd4999);
      add_command(16'h0000, 8'h00, 32'd5000);
      add_command(16'hFFFF, 8'hFF, 32'hFFFF_FFFF);
      // expiry sum past 32 bits still blocks
      add_command(16'hFFFF, 8'hFF, 32'hFFFF_FFFF);
      add_command(16'hFFFF, 8'hFF, 32'd0);
      add_command(16'h8000, 8'h80, 32'h8000_0000);
      add_command(16'h5555, 8'h55, 32'h5555_5555);
      add_command(16'hAAAA, 8'hAA, 32'hAAAA_AAAA);
      add_command(16'h8000, 8'h80, 32'h8000_1388);
      // fill the table and push the oldest entries out
      for (int unsigned i = 0; i < 12; i++)
         add_command(16'(16'h0100 + i), 8'(i), 32'd10 + i);
      wait_for_drain();

      write_timeout(32'hFFFF_FFFF);
      add_command(16'h0001, 8'h01, 32'd0);
      add_command(16'h0001, 8'h01, 32'hFFFF_FFFF);
      add_command(16'h0001, 8'h01, 32'hFFFF_FFFE);
      add_random(RANDOM_PER_PHASE);
      hold_off_asked++;
      wait_for_drain();

      // zero timeout blocks only when time runs backward
      write_timeout(32'd0);
      add_command(16'h0002, 8'h02, 32'd1000);
      add_command(16'h0002, 8'h02, 32'd999);
      add_command(16'h0002, 8'h02, 32'd1000);
      add_random(RANDOM_PER_PHASE);
      wait_for_drain();

      for (int unsigned p = 0; p < 6; p++) begin
         write_timeout(TIMEOUT_PLAN[p]);
         add_random(RANDOM_PER_PHASE);
         if (p == 2)
            hold_off_asked++;
         wait_for_drain();
      end

      write_timeout($urandom);
      add_random(RANDOM_PER_PHASE);
      wait_for_drain();

      $display("covered %0d commands under %0d timeout settings: %0d fresh, %0d blocked",
               beats_in, settings_used, verdicts_fresh, verdicts_blocked);
      if (mismatches == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
